// File: rtl/swpd_pkg.sv
// ============================================================================
// swpd_pkg
// Shared types and constants for the sync word packet deframer.
// ============================================================================
package swpd_pkg;

    // Default framing geometry
    localparam int SYNC_BYTES_DEF   = 4;
    localparam int PREFIX_BYTES_DEF = 8;

    // Fixed header words after the prefix: type, session id, message id
    localparam int ID_BYTES = 12;

    localparam int CNT_W = 21;
    localparam int MAXLEN_W = 21;
    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = MAXLEN_W'(65536);

    // Configuration register indexes
    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SYNC_WORD  = 1'b0;
    localparam t_cfg_idx CFG_MAX_LENGTH = 1'b1;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SHORT = 2'd1;
    localparam t_status ST_LONG  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       clear;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic [31:0] msg_type;
        logic [31:0] session_id;
        logic [31:0] message_id;
        logic [31:0] packet_length;
        logic        is_last;
        t_status     status;
    } t_out_item;

endpackage

// File: rtl/swpd_parser.sv
// ============================================================================
// swpd_parser
// Per-byte framing state: sync hunt, length, header ids and payload, plus
// the configuration registers. Produces at most one result per item.
// ============================================================================
module swpd_parser #(
    parameter int SYNC_BYTES   = swpd_pkg::SYNC_BYTES_DEF,
    parameter int PREFIX_BYTES = swpd_pkg::PREFIX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  swpd_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_accept,
    input  swpd_pkg::t_in_item   i_item,
    output logic                 o_res_valid,
    output swpd_pkg::t_out_item  o_res
);

    localparam int HDR_BYTES = PREFIX_BYTES + swpd_pkg::ID_BYTES;
    localparam int CMP_BYTES = (SYNC_BYTES >= 4) ? 4 : SYNC_BYTES;
    localparam int CMP_BITS  = 8 * CMP_BYTES;
    localparam int CW        = swpd_pkg::CNT_W;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_IDS,
        PH_BODY
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_window, n_window;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0] r_len, n_len;
    logic [31:0] r_type, n_type;
    logic [31:0] r_sess, n_sess;
    logic [31:0] r_msgid, n_msgid;

    logic [31:0] r_sync_word;
    logic [swpd_pkg::MAXLEN_W-1:0] r_max_len;

    logic [7:0]    b;
    logic [CW-1:0] cnt_inc;
    logic [CW-1:0] ids_off;
    logic          hunt_now;
    swpd_pkg::t_status st;

    assign b       = i_item.data_byte;
    assign cnt_inc = r_cnt + CW'(1);
    assign ids_off = r_cnt - CW'(PREFIX_BYTES);

    always_comb begin
        n_phase  = r_phase;
        n_window = r_window;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_type   = r_type;
        n_sess   = r_sess;
        n_msgid  = r_msgid;
        hunt_now = 1'b0;
        st       = swpd_pkg::ST_OK;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            if (i_item.clear) begin
                hunt_now = 1'b1;
            end else begin
                case (r_phase)
                    PH_LEN: begin
                        n_len = {r_len[23:0], b};
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CW'(PREFIX_BYTES)) begin
                            if (n_len < 32'(HDR_BYTES)) begin
                                st = swpd_pkg::ST_SHORT;
                            end else if (n_len > {11'b0, r_max_len}) begin
                                st = swpd_pkg::ST_LONG;
                            end
                            if (st != swpd_pkg::ST_OK) begin
                                o_res_valid = 1'b1;
                                o_res.is_last = 1'b1;
                                o_res.status  = st;
                                hunt_now = 1'b1;
                            end else begin
                                n_phase = PH_IDS;
                            end
                        end
                    end
                    PH_IDS: begin
                        // four bytes per header word, little-endian
                        if (ids_off[CW-1:2] == '0) begin
                            n_type = {b, r_type[31:8]};
                        end else if (ids_off[CW-1:2] == (CW-2)'(1)) begin
                            n_sess = {b, r_sess[31:8]};
                        end else begin
                            n_msgid = {b, r_msgid[31:8]};
                        end
                        n_cnt = cnt_inc;
                        if (cnt_inc >= CW'(HDR_BYTES)) begin
                            if (r_len == 32'(HDR_BYTES)) begin
                                // empty payload: bare completion
                                o_res_valid = 1'b1;
                                o_res.is_last = 1'b1;
                                hunt_now = 1'b1;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        n_cnt = cnt_inc;
                        o_res_valid = 1'b1;
                        o_res.payload_byte  = b;
                        o_res.payload_valid = 1'b1;
                        if ({11'b0, cnt_inc} >= r_len) begin
                            o_res.is_last = 1'b1;
                            hunt_now = 1'b1;
                        end
                    end
                    default: begin
                        n_window = {b, r_window[31:8]};
                        if (r_cnt < CW'(SYNC_BYTES)) begin
                            n_cnt = cnt_inc;
                        end
                        if (n_cnt >= CW'(SYNC_BYTES) &&
                            n_window[31 -: CMP_BITS] == r_sync_word[CMP_BITS-1:0]) begin
                            hunt_now = 1'b1;
                        end
                    end
                endcase
            end

            // result carries the header words as updated by this byte
            o_res.msg_type      = n_type;
            o_res.session_id    = n_sess;
            o_res.message_id    = n_msgid;
            o_res.packet_length = n_len;
            if (!o_res_valid) begin
                o_res = '0;
            end

            if (hunt_now) begin
                n_window = '0;
                n_phase  = PH_HUNT;
                n_cnt    = '0;
                n_len    = '0;
                n_type   = '0;
                n_sess   = '0;
                n_msgid  = '0;
                // sync match in the hunt starts the length field
                if (!i_item.clear && r_phase != PH_LEN && r_phase != PH_IDS &&
                    r_phase != PH_BODY) begin
                    n_phase = PH_LEN;
                    n_cnt   = CW'(SYNC_BYTES);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_window    <= '0;
            r_cnt       <= '0;
            r_len       <= '0;
            r_type      <= '0;
            r_sess      <= '0;
            r_msgid     <= '0;
            r_sync_word <= '0;
            r_max_len   <= swpd_pkg::MAXLEN_RESET;
        end else begin
            r_phase  <= n_phase;
            r_window <= n_window;
            r_cnt    <= n_cnt;
            r_len    <= n_len;
            r_type   <= n_type;
            r_sess   <= n_sess;
            r_msgid  <= n_msgid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    swpd_pkg::CFG_SYNC_WORD:  r_sync_word <= i_cfg_data;
                    swpd_pkg::CFG_MAX_LENGTH: r_max_len <= i_cfg_data[swpd_pkg::MAXLEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // error results carry no header ids
    a_err_no_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != swpd_pkg::ST_OK) |->
        (o_res.is_last && !o_res.payload_valid && o_res.msg_type == '0))
        else $error("length error result with payload or ids");

    // any final result sends the parser back to the hunt
    a_last_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.is_last) |=> (r_phase == PH_HUNT && r_window == '0))
        else $error("parser did not restart hunt after last result");

endmodule

// File: rtl/swpd_obuf.sv
// ============================================================================
// swpd_obuf
// Two-entry output buffer: result register plus skid register, so the
// parser keeps taking bytes while a result waits downstream.
// ============================================================================
module swpd_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  swpd_pkg::t_out_item  i_item,
    output logic                 o_full,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swpd_pkg::t_out_item  o_out_item
);

    logic                r_out_valid, r_skid_valid;
    swpd_pkg::t_out_item r_out, r_skid;
    logic                slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (slot_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_push;
            end
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            r_out <= r_skid_valid ? r_skid : i_item;
        end else if (i_push) begin
            r_skid <= i_item;
        end
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_push)
        else $error("result pushed into full buffer");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");

endmodule

// File: rtl/sync_word_packet_deframer.sv
// ============================================================================
// sync_word_packet_deframer
// Byte-stream deframer: sync word hunt, length-prefixed header, payload out.
// ============================================================================
// One received byte enters per item, and the block takes a new byte every
// clock cycle while input stall is low: each byte needs one pass through the
// phase logic between the parser state registers and the result register,
// so the sustained rate is one item per cycle, and a result (if the byte
// makes one) is registered. Results go through a two-entry buffer (output
// register plus skid register); input stall rises only when both entries are
// held by a stalled consumer. Bytes are discarded until the sync word is
// seen (compared little-endian, at most four bytes of it, and only after
// SYNC_BYTES bytes since the hunt began). A big-endian length field follows,
// counting the whole packet from the first sync byte, then three 32-bit
// little-endian words: type, session id and message id. Each payload byte
// gives one result, the last one flagged with is_last. A packet with no
// payload gives one bare completion result; a length below the header size
// or above max_packet_length gives one error result, and the hunt restarts.
// An item with clear set drops any partial packet and gives no result.
// Configuration writes take effect at once and are meant for idle periods.
module sync_word_packet_deframer #(
    parameter int SYNC_BYTES   = swpd_pkg::SYNC_BYTES_DEF,
    parameter int PREFIX_BYTES = swpd_pkg::PREFIX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  swpd_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    // byte input
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  swpd_pkg::t_in_item   i_in_item,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output swpd_pkg::t_out_item  o_out_item
);

    logic                accept;
    logic                res_valid;
    logic                buf_full;
    swpd_pkg::t_out_item res;

    // stall only while the skid entry is occupied
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    swpd_parser #(
        .SYNC_BYTES   (SYNC_BYTES),
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    swpd_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_item      (res),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: dv/deframer_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// deframer_checker
// Watches both item channels of the deframer, keeps its own copy of the
// parser state, and compares every result item with the predicted one.
// ============================================================================
module deframer_checker #(
    parameter int SYNC_BYTES   = swpd_pkg::SYNC_BYTES_DEF,
    parameter int PREFIX_BYTES = swpd_pkg::PREFIX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  swpd_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  swpd_pkg::t_in_item   i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  swpd_pkg::t_out_item  i_out_item,
    output int                   o_fail_count,
    output int                   o_open_count
);
    import swpd_pkg::*;

    localparam int HDR_BYTES = PREFIX_BYTES + ID_BYTES;
    // only the last sync bytes, at most four, take part in the compare
    localparam int CMP_BYTES = (SYNC_BYTES >= 4) ? 4 : SYNC_BYTES;
    localparam int CMP_SHIFT = 32 - 8 * CMP_BYTES;
    localparam logic [31:0] CMP_MASK =
        (CMP_BYTES >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * CMP_BYTES)) - 32'd1);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_IDS,
        PH_BODY
    } t_phase;

    logic [31:0]         sync_cfg;
    logic [MAXLEN_W-1:0] max_len_cfg;

    logic [31:0]         sync_win;
    t_phase              phase;
    logic [CNT_W-1:0]    byte_cnt;
    logic [31:0]         len_q;
    logic [31:0]         type_q;
    logic [31:0]         session_q;
    logic [31:0]         msgid_q;

    t_out_item           frame_results[$];
    int                  fail_total = 0;
    int                  open_total = 0;

    assign o_fail_count = fail_total;
    assign o_open_count = open_total;

    function void restart_hunt();
        sync_win  = '0;
        phase     = PH_HUNT;
        byte_cnt  = '0;
        len_q     = '0;
        type_q    = '0;
        session_q = '0;
        msgid_q   = '0;
    endfunction

    function void push_result(logic [7:0] b, logic valid, logic last, t_status st);
        t_out_item r;
        r.payload_byte  = b;
        r.payload_valid = valid;
        r.msg_type      = type_q;
        r.session_id    = session_q;
        r.message_id    = msgid_q;
        r.packet_length = len_q;
        r.is_last       = last;
        r.status        = st;
        frame_results.push_back(r);
    endfunction

    // advance the parser by one input item
    function void deframe_byte(t_in_item it);
        t_status st;
        int      word_idx;
        if (it.clear) begin
            restart_hunt();
            return;
        end
        case (phase)
            PH_LENGTH: begin
                len_q    = {len_q[23:0], it.data_byte};
                byte_cnt = byte_cnt + 1'b1;
                if (byte_cnt >= PREFIX_BYTES) begin
                    st = ST_OK;
                    if (len_q < HDR_BYTES)
                        st = ST_SHORT;
                    else if (len_q > 32'(max_len_cfg))
                        st = ST_LONG;
                    if (st != ST_OK) begin
                        push_result(8'd0, 1'b0, 1'b1, st);
                        restart_hunt();
                    end else begin
                        phase = PH_IDS;
                    end
                end
            end
            PH_IDS: begin
                word_idx = (int'(byte_cnt) - PREFIX_BYTES) >> 2;
                case (word_idx)
                    0:       type_q    = {it.data_byte, type_q[31:8]};
                    1:       session_q = {it.data_byte, session_q[31:8]};
                    default: msgid_q   = {it.data_byte, msgid_q[31:8]};
                endcase
                byte_cnt = byte_cnt + 1'b1;
                if (byte_cnt >= HDR_BYTES) begin
                    if (len_q == HDR_BYTES) begin
                        push_result(8'd0, 1'b0, 1'b1, ST_OK);
                        restart_hunt();
                    end else begin
                        phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                byte_cnt = byte_cnt + 1'b1;
                if (32'(byte_cnt) >= len_q) begin
                    push_result(it.data_byte, 1'b1, 1'b1, ST_OK);
                    restart_hunt();
                end else begin
                    push_result(it.data_byte, 1'b1, 1'b0, ST_OK);
                end
            end
            default: begin
                phase    = PH_HUNT;
                sync_win = {it.data_byte, sync_win[31:8]};
                if (byte_cnt < SYNC_BYTES)
                    byte_cnt = byte_cnt + 1'b1;
                if (byte_cnt >= SYNC_BYTES &&
                    ((sync_win >> CMP_SHIFT) & CMP_MASK) == (sync_cfg & CMP_MASK)) begin
                    restart_hunt();
                    phase    = PH_LENGTH;
                    byte_cnt = CNT_W'(SYNC_BYTES);
                end
            end
        endcase
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_total++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function void check_result(t_out_item got);
        t_out_item want;
        if (frame_results.size() == 0) begin
            fail_total++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
            return;
        end
        want = frame_results.pop_front();
        check_field("payload_byte",  32'(want.payload_byte),  32'(got.payload_byte));
        check_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
        check_field("msg_type",      want.msg_type,           got.msg_type);
        check_field("session_id",    want.session_id,         got.session_id);
        check_field("message_id",    want.message_id,         got.message_id);
        check_field("packet_length", want.packet_length,      got.packet_length);
        check_field("is_last",       32'(want.is_last),       32'(got.is_last));
        check_field("status",        32'(want.status),        32'(got.status));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_cfg    = '0;
            max_len_cfg = MAXLEN_RESET;
            restart_hunt();
            frame_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SYNC_WORD:  sync_cfg    = i_cfg_data;
                    CFG_MAX_LENGTH: max_len_cfg = i_cfg_data[MAXLEN_W-1:0];
                    default: ;
                endcase
            end
            // a result leaving now always belongs to an earlier input item
            if (i_out_valid && !i_out_stall)
                check_result(i_out_item);
            if (i_in_valid && !i_in_stall)
                deframe_byte(i_in_item);
        end
        open_total = frame_results.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives byte streams with framed packets, noise, clears and bad lengths
// into the deframer under several sync word and max length settings, with
// random gaps on the input and random stalls on the result side. All result
// checking lives in deframer_checker.
// ============================================================================
module testbench;
    import swpd_pkg::*;

    localparam int HDR_LEN       = PREFIX_BYTES_DEF + ID_BYTES;
    localparam int TOTAL_ITEMS   = 850;
    localparam int PHASE_ITEMS   = 120;   // items between config changes
    localparam int IDLE_LIMIT    = 1000;  // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 4;     // slack after the last predicted result is out

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_cfg_we   = 1'b0;
    t_cfg_idx            i_cfg_idx  = CFG_SYNC_WORD;
    logic [31:0]         i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in_item  = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out_item;

    int                  fail_count;
    int                  open_count;

    // shadow of what was last written, used to shape frames
    logic [31:0]         cur_sync = '0;
    logic [MAXLEN_W-1:0] cur_max  = MAXLEN_RESET;

    int                  item_count = 0;  // input items sent so far
    int                  in_gap_hi  = 19;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    sync_word_packet_deframer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    deframer_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_item    (i_in_item),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_item   (o_out_item),
        .o_fail_count (fail_count),
        .o_open_count (open_count)
    );

    // ------------------------------------------------------------------------
    // Input side. Every task starts and ends on a falling edge. After an item
    // is taken, valid stays high into the next call: that call either lowers
    // it for a gap or puts the next item on at once, so valid never drops and
    // rises within one step, and an accepted item is never offered twice.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [7:0] data, input logic clr);
        int       gap;
        t_in_item it;
        gap          = $urandom_range(0, in_gap_hi);
        it.data_byte = data;
        it.clear     = clr;
        item_count++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item  <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // One frame: sync bytes little-endian, length big-endian, then the three
    // id words and the body only if the length passes the current limits.
    // cut >= 0 replaces the byte at that offset by a clear and drops the rest.
    task automatic send_frame(input logic [31:0] len, input logic [31:0] w_type,
                              input logic [31:0] w_sess, input logic [31:0] w_mid,
                              input int cut);
        logic [7:0] seq[$];
        for (int i = 0; i < 4; i++)
            seq.push_back(cur_sync[8*i +: 8]);
        for (int i = 3; i >= 0; i--)
            seq.push_back(len[8*i +: 8]);
        if (len >= HDR_LEN && len <= 32'(cur_max)) begin
            for (int i = 0; i < 4; i++) seq.push_back(w_type[8*i +: 8]);
            for (int i = 0; i < 4; i++) seq.push_back(w_sess[8*i +: 8]);
            for (int i = 0; i < 4; i++) seq.push_back(w_mid[8*i +: 8]);
            repeat (int'(len) - HDR_LEN) seq.push_back(8'($urandom));
        end
        foreach (seq[i]) begin
            if (i == cut) begin
                send_item(8'($urandom), 1'b1);
                return;
            end
            send_item(seq[i], 1'b0);
        end
    endtask

    // Wait until every predicted result is out, plus a little slack for
    // bytes that make no result.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (open_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] sync, input logic [MAXLEN_W-1:0] maxlen);
        write_reg(CFG_SYNC_WORD, sync);
        write_reg(CFG_MAX_LENGTH, 32'(maxlen));
        cur_sync = sync;
        cur_max  = maxlen;
    endtask

    // ------------------------------------------------------------------------
    // Result side: per result, hold stall for a random count of cycles, then
    // take the next result. Runs of zero-stall results come and go at random.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        int out_gap_hi;
        out_gap_hi = 19;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                out_gap_hi = ($urandom_range(0, 2) == 0) ? 0 : 19;
            gap = $urandom_range(0, out_gap_hi);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Watchdog: any stretch with no handshake on either channel this long
    // means the block has hung.
    initial begin
        int idle;
        idle = 0;
        @(posedge i_rst_n);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle = 0;
            else
                idle++;
        end
        $display("testbench failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] len;
        int          pick;
        int          extra;
        int          lim;
        int          k;
        int          phase_start;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, reset config: sync word 0, max length 65536 ---
        // With a zero sync word the window already matches at reset, so a
        // sync taken before four bytes would turn this into a short error
        // instead of a bare completion.
        send_frame(32'd20, 32'h0, 32'h0, 32'h0, -1);
        send_frame(32'd21, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -1);
        send_frame(32'd19, $urandom, $urandom, $urandom, -1);   // just under header
        send_frame(32'd0, $urandom, $urandom, $urandom, -1);
        send_frame(32'd65537, $urandom, $urandom, $urandom, -1); // just over max
        send_frame(32'hFFFF_FFFF, $urandom, $urandom, $urandom, -1);
        // clear in each parse phase: hunt, length, ids, body
        send_item(8'hA5, 1'b0);
        send_item(8'h00, 1'b1);
        send_frame(32'd26, $urandom, $urandom, $urandom, 2);
        send_frame(32'd26, $urandom, $urandom, $urandom, 6);
        send_frame(32'd26, $urandom, $urandom, $urandom, 13);
        send_frame(32'd26, $urandom, $urandom, $urandom, 23);
        send_frame(32'd26, $urandom, $urandom, $urandom, -1);

        // --- all-ones sync word, tight max ---
        settle();
        set_config(32'hFFFF_FFFF, 21'd24);
        send_frame(32'd24, $urandom, $urandom, $urandom, -1);    // exactly max
        send_frame(32'd25, $urandom, $urandom, $urandom, -1);
        // an extra 0xFF in front: sync hits one byte early, and its last
        // byte is taken as length, never as a second overlapping sync
        send_item(8'hFF, 1'b0);
        send_frame(32'd22, $urandom, $urandom, $urandom, -1);
        settle();
        set_config($urandom, 21'd1048576);
        send_frame(32'd1048577, $urandom, $urandom, $urandom, -1);
        send_frame(32'd20, $urandom, $urandom, $urandom, -1);

        // --- random: mostly well formed frames, some broken ones and noise ---
        phase_start = item_count;
        k = 0;
        while (item_count < TOTAL_ITEMS) begin
            if (item_count - phase_start >= PHASE_ITEMS) begin
                settle();
                case (k % 5)
                    0:       set_config($urandom, 21'd1048576);
                    1:       set_config(32'h0, 21'd20);
                    2:       set_config(32'hFFFF_FFFF, 21'($urandom_range(21, 64)));
                    3:       set_config($urandom, MAXLEN_RESET);
                    default: set_config($urandom, 21'($urandom_range(20, 40)));
                endcase
                k++;
                phase_start = item_count;
            end
            in_gap_hi = ($urandom_range(0, 2) == 0) ? 0 : 19;
            pick  = $urandom_range(0, 99);
            lim   = int'(cur_max) - HDR_LEN;
            extra = $urandom_range(0, (pick < 5) ? 60 : 12);
            if (extra > lim)
                extra = lim;
            len = 32'(HDR_LEN + extra);
            if (pick < 60) begin
                send_frame(len, $urandom, $urandom, $urandom, -1);
            end else if (pick < 70) begin
                send_frame(32'($urandom_range(0, HDR_LEN - 1)),
                           $urandom, $urandom, $urandom, -1);
            end else if (pick < 78) begin
                case ($urandom_range(0, 2))
                    0:       len = 32'hFFFF_FFFF;
                    1:       len = 32'(cur_max) + 32'd1;
                    default: len = $urandom | 32'h0020_0000;
                endcase
                send_frame(len, $urandom, $urandom, $urandom, -1);
            end else if (pick < 88) begin
                send_frame(len, $urandom, $urandom, $urandom,
                           $urandom_range(0, int'(len) - 1));
            end else begin
                repeat ($urandom_range(1, 8))
                    send_item(8'($urandom), ($urandom_range(0, 7) == 0));
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && open_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
